[hw/rtl/skct_pkg.sv]
// shared types, codes and constants of the sorted key/count table
package skct_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int KEY_BITS_DEF    = 64;

  localparam int KEY_FIELD_BITS  = 64;
  localparam int AMOUNT_BITS     = 16;
  localparam int COUNT_BITS      = 32;
  localparam int STATUS_BITS     = 3;
  localparam int HELD_BITS       = 6;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_MERGED   = 3'd0,
    ST_INSERTED = 3'd1,
    ST_TAKEN    = 3'd2,
    ST_MISS     = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_TAKE   = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_WRITE,
    CMD_REMOVE
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  typedef struct packed {
    logic                      action;
    logic [KEY_FIELD_BITS-1:0] key;
    logic [AMOUNT_BITS-1:0]    amount;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [COUNT_BITS-1:0]  key_count;
    logic [HELD_BITS-1:0]   entries_held;
  } out_item_t;

  typedef struct packed {
    cell_cmd_t             cmd;
    logic [COUNT_BITS-1:0] count;
  } cell_ctl_t;

endpackage

[hw/rtl/sorted_key_count_table.sv]
// top level of the sorted key/count table: row of slot cells and the sequencer
//
//  channel  direction  ports                       transfer when
//  -------  ---------  --------------------------  -------------------------
//  input    in         start, busy, in_data        start high and busy low
//  result   out        out_valid, out_data         out_valid high (one cycle)
//
// each item is handled as follows: at the accepting edge each cell compares its key
// against the incoming key in parallel; in the following cycle the hit count
// is selected, the new count worked out and the row shifts or writes at the
// edge that also registers the result. busy is high for that update cycle.
// the next item can be accepted in the cycle the result is shown.
// synchronous reset clears the entry count and the sequencer; slot contents
// stay undefined and are never read before being written (no clearing pass).
// the receiver cannot stall: each result is shown for exactly one cycle.
module sorted_key_count_table #(
  parameter int TABLE_DEPTH = skct_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = skct_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  skct_pkg::in_item_t  in_data,
  output logic                out_valid,
  output skct_pkg::out_item_t out_data
);
  import skct_pkg::*;

  // entry count needs to hold the depth itself
  localparam int TW = $clog2(TABLE_DEPTH + 1);

  state_t                state_r, state_nxt;
  logic [TW-1:0]         total_r, total_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r;

  // operation held for the update cycle
  logic                  act_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [AMOUNT_BITS-1:0] amt_r;

  logic                  accept;
  logic [KEY_BITS-1:0]   in_key;

  // row of cells
  logic [KEY_BITS-1:0]   key_a   [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] cnt_a   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ge_v;
  logic [TABLE_DEPTH-1:0] eq_v;
  logic [TABLE_DEPTH-1:0] occ_v;
  cell_ctl_t             ctl;

  // update cycle arithmetic
  logic                  hit;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic [COUNT_BITS:0]   sum_w;
  logic [COUNT_BITS-1:0] sat_cnt;
  logic [COUNT_BITS-1:0] amt_w;
  logic [COUNT_BITS-1:0] diff_cnt;
  logic                  short_w;
  logic                  full;
  status_t               res_status;
  logic [COUNT_BITS-1:0] res_count;
  logic [TW+HELD_BITS-1:0] held_ext;

  assign accept = start && !busy;
  assign in_key = in_data.key[KEY_BITS-1:0];   // upper key bits are ignored

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_data.action;
      key_r <= in_key;
      amt_r <= in_data.amount;
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic                  lge;
    logic [KEY_BITS-1:0]   lkey, rkey;
    logic [COUNT_BITS-1:0] lcnt, rcnt;

    // a slot is held while its index is below the entry count
    assign occ_v[g] = total_r > TW'(g);

    if (g == 0) begin : g_first
      assign lge  = 1'b0;
      assign lkey = '0;
      assign lcnt = '0;
    end else begin : g_mid
      assign lge  = ge_v[g-1];
      assign lkey = key_a[g-1];
      assign lcnt = cnt_a[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign rkey = '0;
      assign rcnt = '0;
    end else begin : g_inner
      assign rkey = key_a[g+1];
      assign rcnt = cnt_a[g+1];
    end

    skct_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmp_en      (accept),
      .cmp_key     (in_key),
      .occ         (occ_v[g]),
      .ctl         (ctl),
      .new_key     (key_r),
      .left_ge     (lge),
      .left_key    (lkey),
      .left_count  (lcnt),
      .right_key   (rkey),
      .right_count (rcnt),
      .key_o       (key_a[g]),
      .count_o     (cnt_a[g]),
      .ge_o        (ge_v[g]),
      .eq_o        (eq_v[g])
    );
  end

  // at most one cell matches, so an or of the gated counts selects it
  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_cnt = hit_cnt | (cnt_a[i] & {COUNT_BITS{eq_v[i]}});
    end
  end

  assign hit      = |eq_v;
  assign full     = total_r == TW'(TABLE_DEPTH);
  assign amt_w    = COUNT_BITS'(amt_r);
  assign sum_w    = (COUNT_BITS+1)'(hit_cnt) + (COUNT_BITS+1)'(amt_r);
  assign sat_cnt  = sum_w[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum_w[COUNT_BITS-1:0];
  assign short_w  = hit_cnt < amt_w;
  assign diff_cnt = hit_cnt - amt_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    ctl.cmd       = CMD_NONE;
    ctl.count     = sat_cnt;
    res_status    = ST_MISS;
    res_count     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (act_r == ACT_INSERT) begin
          if (hit) begin
            // merge, count saturates at the top of its range
            ctl.cmd    = CMD_WRITE;
            ctl.count  = sat_cnt;
            res_status = ST_MERGED;
            res_count  = sat_cnt;
          end else if (full) begin
            res_status = ST_FULL;
          end else begin
            // new entry at its sorted slot, larger keys move up one
            ctl.cmd    = CMD_INSERT;
            ctl.count  = amt_w;
            res_status = ST_INSERTED;
            res_count  = amt_w;
            total_nxt  = total_r + TW'(1);
          end
        end else begin
          if (!hit) begin
            res_status = ST_MISS;
          end else if (short_w) begin
            res_status = ST_MISS;
            res_count  = hit_cnt;
          end else if (diff_cnt != '0) begin
            ctl.cmd    = CMD_WRITE;
            ctl.count  = diff_cnt;
            res_status = ST_TAKEN;
            res_count  = diff_cnt;
          end else begin
            // emptied entry leaves, larger keys close the gap
            ctl.cmd    = CMD_REMOVE;
            res_status = ST_TAKEN;
            total_nxt  = total_r - TW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign held_ext = {{HELD_BITS{1'b0}}, total_nxt};

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_data_r.status       <= res_status;
      out_data_r.key_count    <= res_count;
      out_data_r.entries_held <= held_ext[HELD_BITS-1:0];
    end
  end

  assign busy      = state_r == S_UPD;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result only ever follows an update cycle
  a_out_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_UPD))
    else $error("result strobe without an update cycle");

  // the entry count never passes the depth
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // keys stay unique, so no more than one cell can match
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_v))
    else $error("more than one cell matched the key");

  // the count moves by at most one and only on the edge that ends an update
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> $stable(total_r) || $past(!rst_n))
    else $error("entry count changed outside an update");

endmodule

[hw/rtl/skct_cell.sv]
// one table slot: holds a key and count, compares and shifts with its neighbours
module skct_cell #(
  parameter int KEY_BITS = skct_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmp_en,
  input  logic [KEY_BITS-1:0]             cmp_key,
  input  logic                            occ,
  input  skct_pkg::cell_ctl_t             ctl,
  input  logic [KEY_BITS-1:0]             new_key,
  input  logic                            left_ge,
  input  logic [KEY_BITS-1:0]             left_key,
  input  logic [skct_pkg::COUNT_BITS-1:0] left_count,
  input  logic [KEY_BITS-1:0]             right_key,
  input  logic [skct_pkg::COUNT_BITS-1:0] right_count,
  output logic [KEY_BITS-1:0]             key_o,
  output logic [skct_pkg::COUNT_BITS-1:0] count_o,
  output logic                            ge_o,
  output logic                            eq_o
);
  import skct_pkg::*;

  logic [KEY_BITS-1:0]   key_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  ge_r;
  logic                  eq_r;

  // empty slots count as above every key, so ge is monotone along the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (cmp_en) begin
      ge_r <= !occ || (key_r >= cmp_key);
      eq_r <= occ && (key_r == cmp_key);
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_INSERT: begin
        if (ge_r && !left_ge) begin
          key_r   <= new_key;
          count_r <= ctl.count;
        end else if (ge_r) begin
          key_r   <= left_key;
          count_r <= left_count;
        end
      end
      CMD_WRITE: begin
        if (eq_r) count_r <= ctl.count;
      end
      CMD_REMOVE: begin
        if (ge_r) begin
          key_r   <= right_key;
          count_r <= right_count;
        end
      end
      CMD_NONE: ;
      default: ;
    endcase
  end

  assign key_o   = key_r;
  assign count_o = count_r;
  assign ge_o    = ge_r;
  assign eq_o    = eq_r;

endmodule
